@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ design/mcpg_pkg.sv @@
// ----------------------------------------------------------------------------
// mcpg_pkg
// Widths, limits and octant codes of the midpoint circle point generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpg_pkg;

    localparam int CoordInW  = 16;   // center coordinate and radius
    localparam int ColourW   = 24;
    localparam int PointW    = 18;   // emitted coordinate
    localparam int OffsetW   = 17;   // signed offset, x may dip to -1
    localparam int ErrW      = 20;   // signed midpoint decision variable
    localparam int StepMax   = 64;   // most points emitted per accepted transaction
    localparam int CntW      = $clog2(StepMax);
    localparam int InDataW   = 72;
    localparam int OutDataW  = 64;

    localparam logic [2:0] OCT_PXPY = 3'd0;
    localparam logic [2:0] OCT_PYPX = 3'd1;
    localparam logic [2:0] OCT_NXPY = 3'd2;
    localparam logic [2:0] OCT_NYPX = 3'd3;
    localparam logic [2:0] OCT_NXNY = 3'd4;
    localparam logic [2:0] OCT_NYNX = 3'd5;
    localparam logic [2:0] OCT_PXNY = 3'd6;
    localparam logic [2:0] OCT_PYNX = 3'd7;

    localparam logic FUNC_OUTLINE = 1'b0;
    localparam logic FUNC_FILLED  = 1'b1;

endpackage

`default_nettype wire

@@ design/midpoint_circle_point_generator_top.sv @@
// ----------------------------------------------------------------------------
// midpoint_circle_point_generator_top
// Midpoint circle rasterizer: outline or filled (concentric rings) circles.
// ----------------------------------------------------------------------------
// The first point of a transaction is registered onto m_tdata once the state is ST_RUN.
// Throughput: one point per cycle while m_tready is high, set by the single point
//   adder pair stepped by the octant sequencer; each accepted transaction emits up
//   to 64 points with s_tready low, then s_tready goes high for the next one.
//   A busy run continues on the next transaction, whose payload is then ignored.
// Reset: aresetn (synchronous, active low) clears state, counter, run flag and m_tvalid.
`default_nettype none

`include "assert_macros.svh"

module midpoint_circle_point_generator_top
    import mcpg_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // s_tdata: center_x[15:0], center_y[31:16], radius[47:32], draw_colour[71:48]
    input  wire logic [InDataW-1:0]   s_tdata,
    // s_tuser: func
    input  wire logic                 s_tuser,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // m_tdata: point_x[17:0], point_y[35:18], point_colour[59:36], zero[63:60]
    output logic [OutDataW-1:0]       m_tdata,
    output logic                      m_tlast,
    output logic                      m_tvalid,
    input  wire logic                 m_tready
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t                      state_reg, state_next;
    logic                        busy_reg, busy_next;
    logic                        fill_reg, fill_next;
    logic signed [CoordInW-1:0]  cx_reg, cx_next;
    logic signed [CoordInW-1:0]  cy_reg, cy_next;
    logic [ColourW-1:0]          colour_reg, colour_next;
    logic [CoordInW-1:0]         target_reg, target_next;
    logic [CoordInW-1:0]         ring_reg, ring_next;
    logic signed [OffsetW-1:0]   ox_reg, ox_next;
    logic signed [OffsetW-1:0]   oy_reg, oy_next;
    logic signed [ErrW-1:0]      err_reg, err_next;
    logic [2:0]                  oct_reg, oct_next;
    logic [CntW-1:0]             cnt_reg, cnt_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [OutDataW-1:0]         m_tdata_reg, m_tdata_next;
    logic                        m_tlast_reg, m_tlast_next;

    logic                        load;
    logic signed [PointW-1:0]    sx, sy, dx, dy, px, py;
    logic signed [OffsetW-1:0]   y_inc, x_dec, x_adv;
    logic signed [ErrW-1:0]      err_adv;
    logic                        ring_done, more_rings, run_end;
    logic [CoordInW-1:0]         start_r, ring_inc;
    logic [CoordInW-1:0]         in_radius;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    assign load = (state_reg == ST_RUN) && (!m_tvalid_reg || m_tready);

    // Point adder: center plus the signed octant offset.
    always_comb begin
        sx = PointW'(ox_reg);
        sy = PointW'(oy_reg);
        case (oct_reg)
            OCT_PXPY: begin dx =  sx; dy =  sy; end
            OCT_PYPX: begin dx =  sy; dy =  sx; end
            OCT_NXPY: begin dx = -sx; dy =  sy; end
            OCT_NYPX: begin dx = -sy; dy =  sx; end
            OCT_NXNY: begin dx = -sx; dy = -sy; end
            OCT_NYNX: begin dx = -sy; dy = -sx; end
            OCT_PXNY: begin dx =  sx; dy = -sy; end
            default:  begin dx =  sy; dy = -sx; end
        endcase
        px = PointW'(cx_reg) + dx;
        py = PointW'(cy_reg) + dy;
    end

    // Decision update after the eighth point of an iteration.
    always_comb begin
        y_inc = oy_reg + OffsetW'(1);
        x_dec = ox_reg - OffsetW'(1);
        if (err_reg < 0) begin
            x_adv   = ox_reg;
            err_adv = err_reg + (ErrW'(y_inc) <<< 1) + ErrW'(1);
        end else begin
            x_adv   = x_dec;
            err_adv = err_reg + ((ErrW'(y_inc) - ErrW'(x_dec) + ErrW'(1)) <<< 1);
        end
        ring_done  = (oct_reg == OCT_PYNX) && (x_adv < y_inc);
        more_rings = fill_reg && (ring_reg < target_reg);
        run_end    = ring_done && !more_rings;
        ring_inc   = ring_reg + CoordInW'(1);
    end

    assign in_radius = s_tdata[47:32];
    assign start_r   = (s_tuser == FUNC_FILLED) ? '0 : in_radius;

    always_comb begin
        state_next    = state_reg;
        busy_next     = busy_reg;
        fill_next     = fill_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        colour_next   = colour_reg;
        target_next   = target_reg;
        ring_next     = ring_reg;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        err_next      = err_reg;
        oct_next      = oct_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                    // Payload is taken only when no run is pending.
                    if (!busy_reg) begin
                        busy_next   = 1'b1;
                        fill_next   = s_tuser;
                        cx_next     = s_tdata[15:0];
                        cy_next     = s_tdata[31:16];
                        target_next = in_radius;
                        colour_next = s_tdata[71:48];
                        ring_next   = start_r;
                        ox_next     = OffsetW'(start_r);
                        oy_next     = '0;
                        err_next    = ErrW'(1) - ErrW'(start_r);
                        oct_next    = OCT_PXPY;
                    end
                end
            end
            ST_RUN: begin
                if (load) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, colour_reg, py, px};
                    m_tlast_next  = run_end;
                    cnt_next      = cnt_reg + CntW'(1);
                    if (oct_reg != OCT_PYNX) begin
                        oct_next = oct_reg + 3'd1;
                    end else if (!ring_done) begin
                        oct_next = OCT_PXPY;
                        oy_next  = y_inc;
                        ox_next  = x_adv;
                        err_next = err_adv;
                    end else if (more_rings) begin
                        // Start the next concentric ring.
                        oct_next  = OCT_PXPY;
                        ring_next = ring_inc;
                        ox_next   = OffsetW'(ring_inc);
                        oy_next   = '0;
                        err_next  = -ErrW'(ring_reg);
                    end else begin
                        oct_next = OCT_PXPY;
                        oy_next  = y_inc;
                        ox_next  = x_adv;
                        err_next = err_adv;
                    end
                    if (run_end) begin
                        busy_next  = 1'b0;
                        state_next = ST_IDLE;
                    end else if (cnt_reg == CntW'(StepMax - 1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
        end
        fill_reg    <= fill_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        colour_reg  <= colour_next;
        target_reg  <= target_next;
        ring_reg    <= ring_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        err_reg     <= err_next;
        oct_reg     <= oct_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    `ASSERT_IMPL(a_run_has_busy, state_reg == ST_RUN, busy_reg)
    `ASSERT_IMPL(a_ring_in_octant, state_reg == ST_RUN, ox_reg >= oy_reg)
    `ASSERT_NEXT(a_new_run_starts, s_tvalid && s_tready && !busy_reg,
                 oct_reg == OCT_PXPY && oy_reg == '0 && busy_reg)

endmodule

`default_nettype wire
